// File: rtl/core/tcc_pkg.sv
// tcc_pkg: shared types and constants of the text console cursor engine.
// No dependencies; imported by the channel interfaces and all modules but tcc_ram.
package tcc_pkg;

   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int POS_W    = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
   localparam logic [CHAR_W-1:0] BS_CODE    = 8'd8;
   localparam logic [CHAR_W-1:0] BLANK_CODE = 8'd32;
   localparam logic [ATTR_W-1:0] COLOR_RESET = 8'd15;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NL,
      ST_NL_ADV,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_BS,
      ST_BS_WR,
      ST_WRITE,
      ST_READ,
      ST_RDCAP,
      ST_DONE
   } state_type;

endpackage

// File: rtl/core/tcc_req_if.sv
// tcc_req_if: request channel (valid/ready plus action, char and cell index).
// Depends on tcc_pkg for field widths.
interface tcc_req_if;
   import tcc_pkg::*;

   logic               valid;
   logic               ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]  char_code;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output action, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input action, input char_code, input cell_index,
                   output ready);
endinterface

// File: rtl/core/tcc_rsp_if.sv
// tcc_rsp_if: response channel (valid/ready plus cursor position and cell read).
// Depends on tcc_pkg for field widths.
interface tcc_rsp_if;
   import tcc_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_pos;
   logic [CHAR_W-1:0] read_char;
   logic [ATTR_W-1:0] read_attr;

   modport source (output valid, output cursor_pos, output read_char, output read_attr,
                   input ready);
   modport sink   (input valid, input cursor_pos, input read_char, input read_attr,
                   output ready);
endinterface

// File: rtl/core/tcc_ram.sv
// tcc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/tcc_alu.sv
// tcc_alu: shared address adder/subtractor with a less-than compare on the sum.
// Depends on tcc_pkg (alu_op_type).
module tcc_alu #(
   parameter int W = 11
) (
   input  tcc_pkg::alu_op_type op,
   input  logic [W-1:0]        a,
   input  logic [W-1:0]        b,
   input  logic [W-1:0]        lim,
   output logic [W-1:0]        y,
   output logic                lt
);
   import tcc_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a;
      endcase
      lt = (y < lim);
   end
endmodule

// File: rtl/core/tcc_seq.sv
// tcc_seq: sequencer of the console engine; cursor state, text color, result register.
// Depends on tcc_pkg, tcc_req_if, tcc_rsp_if; drives tcc_alu and tcc_ram from the top.
module tcc_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELLS  = ROWS * COLUMNS,
   localparam int AW     = $clog2(CELLS + 1),
   localparam int RAW    = $clog2(CELLS)
) (
   input  logic                      clock,
   input  logic                      reset,
   tcc_req_if.sink                   req_chan,
   tcc_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_en,
   input  logic [tcc_pkg::ATTR_W-1:0] csr_write_data,
   output tcc_pkg::alu_op_type       alu_op,
   output logic [AW-1:0]             alu_a,
   output logic [AW-1:0]             alu_b,
   output logic [AW-1:0]             alu_lim,
   input  logic [AW-1:0]             alu_y,
   input  logic                      alu_lt,
   output logic                      ram_wr_en,
   output logic [RAW-1:0]            ram_wr_addr,
   output logic [tcc_pkg::CELL_W-1:0] ram_wr_data,
   output logic [RAW-1:0]            ram_rd_addr,
   input  logic [tcc_pkg::CELL_W-1:0] ram_rd_data
);
   import tcc_pkg::*;

   localparam int CW = $clog2(COLUMNS + 1);
   localparam int RW = $clog2(ROWS);
   localparam int PW = (AW > POS_W) ? AW : POS_W;
   localparam int IW = ((RAW > INDEX_W) ? RAW : INDEX_W) + 1;

   state_type           state_ff, state_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                put_after_ff, put_after_in;
   logic [ATTR_W-1:0]   color_ff, color_in;
   logic [CHAR_W-1:0]   rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0]   rd_attr_ff, rd_attr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;

   logic [PW-1:0] pos_ext;
   logic [IW-1:0] idx_ext;
   logic [IW-1:0] req_idx_ext;

   assign pos_ext     = PW'(addr_ff);
   assign idx_ext     = IW'(idx_ff);
   assign req_idx_ext = IW'(req_chan.cell_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         addr_ff      <= '0;
         ptr_ff       <= '0;
         put_after_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         addr_ff      <= addr_in;
         ptr_ff       <= ptr_in;
         put_after_ff <= put_after_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      char_ff     <= char_in;
      idx_ff      <= idx_in;
      rd_char_ff  <= rd_char_in;
      rd_attr_ff  <= rd_attr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      ptr_in       = ptr_ff;
      act_in       = act_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      put_after_in = put_after_ff;
      color_in     = csr_write_en ? csr_write_data : color_ff;
      rd_char_in   = rd_char_ff;
      rd_attr_in   = rd_attr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;

      alu_op      = ALU_ADD;
      alu_a       = addr_ff;
      alu_b       = '0;
      alu_lim     = AW'(CELLS);
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff[RAW-1:0];
      ram_wr_data = {color_ff, char_ff};
      ram_rd_addr = idx_ext[RAW-1:0];

      req_chan.ready = (state_ff == ST_IDLE);

      // response slot frees on its beat
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in       = req_chan.action;
               char_in      = req_chan.char_code;
               idx_in       = req_chan.cell_index;
               rd_char_in   = '0;
               rd_attr_in   = '0;
               put_after_in = 1'b0;
               case (action_type'(req_chan.action))
                  ACT_PUT: begin
                     if (req_chan.char_code == NL_CODE) begin
                        state_in = ST_NL;
                     end else if (req_chan.char_code == BS_CODE) begin
                        state_in = ST_BS;
                     end else if (col_ff >= CW'(COLUMNS)) begin
                        put_after_in = 1'b1;
                        state_in     = ST_NL;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  ACT_CLEAR: begin
                     ptr_in   = '0;
                     state_in = ST_BLANK;
                  end
                  ACT_READ: begin
                     state_in = (req_idx_ext < IW'(CELLS)) ? ST_READ : ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_NL: begin
            // back to the start of the line
            alu_op  = ALU_SUB;
            alu_b   = AW'(col_ff);
            addr_in = alu_y;
            col_in  = '0;
            if (row_ff < RW'(ROWS - 1)) begin
               state_in = ST_NL_ADV;
            end else begin
               ptr_in   = '0;
               state_in = ST_SCROLL_RD;
            end
         end
         ST_NL_ADV: begin
            alu_b    = AW'(COLUMNS);
            addr_in  = alu_y;
            row_in   = row_ff + RW'(1);
            state_in = put_after_ff ? ST_WRITE : ST_DONE;
         end
         ST_SCROLL_RD: begin
            alu_a       = ptr_ff;
            alu_b       = AW'(COLUMNS);
            ram_rd_addr = alu_y[RAW-1:0];
            state_in    = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff[RAW-1:0];
            ram_wr_data = ram_rd_data;
            alu_a       = ptr_ff;
            alu_b       = AW'(1);
            alu_lim     = AW'(CELLS - COLUMNS);
            ptr_in      = alu_y;
            state_in    = alu_lt ? ST_SCROLL_RD : ST_BLANK;
         end
         ST_BLANK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff[RAW-1:0];
            ram_wr_data = {color_ff, BLANK_CODE};
            alu_a       = ptr_ff;
            alu_b       = AW'(1);
            ptr_in      = alu_y;
            if (!alu_lt) begin
               if (act_ff == ACT_CLEAR) begin
                  col_in   = '0;
                  row_in   = '0;
                  addr_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = put_after_ff ? ST_WRITE : ST_DONE;
               end
            end
         end
         ST_BS: begin
            // at home the cursor stays put
            alu_op  = ALU_SUB;
            alu_b   = AW'((col_ff != '0) || (row_ff != '0));
            addr_in = alu_y;
            if (col_ff != '0) begin
               col_in = col_ff - CW'(1);
            end else if (row_ff != '0) begin
               row_in = row_ff - RW'(1);
               col_in = CW'(COLUMNS - 1);
            end
            state_in = ST_BS_WR;
         end
         ST_BS_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {color_ff, BLANK_CODE};
            state_in    = ST_DONE;
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            alu_b     = AW'(1);
            addr_in   = alu_y;
            col_in    = col_ff + CW'(1);
            state_in  = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_RDCAP;
         end
         ST_RDCAP: begin
            rd_char_in = ram_rd_data[CHAR_W-1:0];
            rd_attr_in = ram_rd_data[CELL_W-1:CHAR_W];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ext[POS_W-1:0];
               rsp_char_in  = rd_char_ff;
               rsp_attr_in  = rd_attr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_pos = rsp_pos_ff;
   assign rsp_chan.read_char  = rsp_char_ff;
   assign rsp_chan.read_attr  = rsp_attr_ff;
endmodule

// File: rtl/core/text_console_cursor_engine_top.sv
// text_console_cursor_engine_top: text console with a cell store and a cursor.
// From accept to result valid: char WRITE; newline NL, NL_ADV (wrap adds WRITE); backspace
//   BS, BS_WR; in-range read READ, RDCAP; last-row newline NL, SCROLL_RD/SCROLL_WR per cell,
//   BLANK per last-row cell; clear BLANK per cell; all end in DONE. One item at a time: the
//   next beat is taken in the cycle the result goes valid; a result still waiting holds it off.
// Reset (sync, high): cursor home, text_color 15; the cell store is not cleared.
module text_console_cursor_engine_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   tcc_req_if.sink                   req_chan,
   tcc_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_en,
   input  logic [tcc_pkg::ATTR_W-1:0] csr_write_data
);
   import tcc_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS + 1);   // cursor address, may reach CELLS
   localparam int RAW   = $clog2(CELLS);       // cell RAM address

   // shared address unit hookup
   alu_op_type    alu_op;
   logic [AW-1:0] alu_a, alu_b, alu_lim, alu_y;
   logic          alu_lt;

   // cell store hookup: {attr, char}
   logic              ram_wr_en;
   logic [RAW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

   // Sequencer: decodes each beat, walks cells for scroll and clear,
   // keeps cursor row/col/linear address and the text color.
   tcc_seq #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .alu_op        (alu_op),
      .alu_a         (alu_a),
      .alu_b         (alu_b),
      .alu_lim       (alu_lim),
      .alu_y         (alu_y),
      .alu_lt        (alu_lt),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   // One adder serves cursor moves, scroll source addresses and sweep pointers.
   tcc_alu #(
      .W(AW)
   ) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .lim(alu_lim),
      .y  (alu_y),
      .lt (alu_lt)
   );

   // Screen cells, undefined until written.
   tcc_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELLS)
   ) u_cells (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );
endmodule
